/* rtl/iol_pkg.sv */
// Types and constants shared by the indexed ordered list.
// Used by the cell and the top level.
package iol_pkg;

  localparam int DATA_W = 32;
  localparam int CW     = 7;

  localparam logic [2:0] KIND_INSERT     = 3'd0;
  localparam logic [2:0] KIND_APPEND     = 3'd1;
  localparam logic [2:0] KIND_DELETE_END = 3'd2;
  localparam logic [2:0] KIND_DELETE_AT  = 3'd3;
  localparam logic [2:0] KIND_UPDATE     = 3'd4;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_INSERT,
    CMD_APPEND,
    CMD_UPDATE,
    CMD_DELETE,
    CMD_DROP,
    CMD_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [CW-1:0]   pos;
    logic [CW-1:0]   count;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               position;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [3:0]               slot;
    logic                     last;
    logic                     is_empty;
    logic [1:0]               error;
    logic [4:0]               length;
  } rsp_t;

endpackage

/* rtl/iol_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
// Payload type is set by the payload_t parameter.
interface iol_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/indexed_ordered_list.sv */
// Indexed ordered list: command decode, sequencer and the chain of slot cells.
// Depends on iol_pkg, iol_stream_if and iol_cell.
// A command is applied in S_APPLY and its results are registered in S_EMIT;
// no new command is taken until its last result is loaded. With the sink ready,
// results leave at one per cycle as the chain rotates the list past slot 0.
// Reset clears the length to zero; slot contents stay undefined until written.
module indexed_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  iol_stream_if.sink          cmd,
  iol_stream_if.source        rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = iol_pkg::CW;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_EMIT} state_t;

  state_t                            state;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  k;
  iol_pkg::cell_op_t                 act;
  iol_pkg::cell_op_t                 act_next;
  logic [1:0]                        err;
  logic [1:0]                        err_next;
  logic [CW-1:0]                     pos;
  logic signed [iol_pkg::DATA_W-1:0] value;
  logic                              out_valid;
  iol_pkg::rsp_t                     out_data;

  logic [CW-1:0]                     count_w;
  logic [CW-1:0]                     k_w;
  logic [CW-1:0]                     cmd_pos;
  logic                              cmd_fire;
  logic                              load;
  logic                              final_out;
  iol_pkg::cell_ctrl_t               ctrl;
  logic signed [iol_pkg::DATA_W-1:0] q [CAPACITY];

  assign count_w   = CW'(count);
  assign k_w       = CW'(k);
  assign cmd_pos   = CW'(cmd.data.position);
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign load      = !out_valid || rsp.ready;
  assign final_out = (count == '0) || (k_w + 1'b1 == count_w);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    act_next = iol_pkg::CMD_IDLE;
    err_next = iol_pkg::ERR_OK;
    unique case (cmd.data.kind)
      iol_pkg::KIND_INSERT: begin
        if (cmd_pos > count_w)    err_next = iol_pkg::ERR_RANGE;
        else if (count_w == CAP)  err_next = iol_pkg::ERR_FULL;
        else                      act_next = iol_pkg::CMD_INSERT;
      end
      iol_pkg::KIND_APPEND: begin
        if (count_w == CAP) err_next = iol_pkg::ERR_FULL;
        else                act_next = iol_pkg::CMD_APPEND;
      end
      iol_pkg::KIND_DELETE_END: begin
        if (count == '0) err_next = iol_pkg::ERR_EMPTY;
        else             act_next = iol_pkg::CMD_DROP;
      end
      iol_pkg::KIND_DELETE_AT: begin
        if (count == '0)            err_next = iol_pkg::ERR_EMPTY;
        else if (cmd_pos >= count_w) err_next = iol_pkg::ERR_RANGE;
        else                        act_next = iol_pkg::CMD_DELETE;
      end
      iol_pkg::KIND_UPDATE: begin
        if (cmd_pos >= count_w) err_next = iol_pkg::ERR_RANGE;
        else                    act_next = iol_pkg::CMD_UPDATE;
      end
      default: begin
        act_next = iol_pkg::CMD_IDLE;
        err_next = iol_pkg::ERR_OK;
      end
    endcase
  end

  always_comb begin
    ctrl.pos   = pos;
    ctrl.count = count_w;
    ctrl.op    = iol_pkg::CMD_IDLE;
    if (state == S_APPLY) begin
      ctrl.op = act;
    end else if (state == S_EMIT && load && count != '0) begin
      ctrl.op = iol_pkg::CMD_ROTATE;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [iol_pkg::DATA_W-1:0] left;
    logic signed [iol_pkg::DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid_r
      assign right = q[g+1];
    end
    iol_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_value (value),
      .left      (left),
      .right     (right),
      .head      (q[0]),
      .q         (q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            act   <= act_next;
            err   <= err_next;
            pos   <= cmd_pos;
            value <= cmd.data.value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (act == iol_pkg::CMD_INSERT || act == iol_pkg::CMD_APPEND) begin
            count <= count + 1'b1;
          end else if (act == iol_pkg::CMD_DELETE || act == iol_pkg::CMD_DROP) begin
            count <= count - 1'b1;
          end
          k     <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            k <= k + 1'b1;
            if (final_out) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_EMIT && load) begin
        out_valid         <= 1'b1;
        out_data.item     <= (count == '0) ? '0 : q[0];
        out_data.slot     <= k_w[3:0];
        out_data.last     <= final_out;
        out_data.is_empty <= (count == '0);
        out_data.error    <= err;
        out_data.length   <= count_w[4:0];
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= CAP)
    else $error("length exceeds capacity");

  a_accept_apply: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> state == S_APPLY)
    else $error("accepted command not applied");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY && err != iol_pkg::ERR_OK |=> $stable(count))
    else $error("rejected command changed length");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && count != '0 |-> k < count)
    else $error("emit index past length");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |-> out_data.last && out_data.length == '0)
    else $error("empty result not final");

endmodule

/* rtl/iol_cell.sv */
// One list slot of the cell chain: holds an entry and takes a neighbor's,
// the new value or the head value as the broadcast control selects. Uses iol_pkg.
module iol_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  iol_pkg::cell_ctrl_t              ctrl,
  input  logic signed [iol_pkg::DATA_W-1:0] new_value,
  input  logic signed [iol_pkg::DATA_W-1:0] left,
  input  logic signed [iol_pkg::DATA_W-1:0] right,
  input  logic signed [iol_pkg::DATA_W-1:0] head,
  output logic signed [iol_pkg::DATA_W-1:0] q
);

  localparam logic [iol_pkg::CW-1:0] I = iol_pkg::CW'(IDX);

  logic signed [iol_pkg::DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      iol_pkg::CMD_INSERT: begin
        if (I == ctrl.pos) begin
          q_next = new_value;
        end else if (I > ctrl.pos && I <= ctrl.count) begin
          q_next = left;
        end
      end
      iol_pkg::CMD_APPEND: begin
        if (I == ctrl.count) q_next = new_value;
      end
      iol_pkg::CMD_UPDATE: begin
        if (I == ctrl.pos) q_next = new_value;
      end
      iol_pkg::CMD_DELETE: begin
        if (I >= ctrl.pos && I + 1'b1 < ctrl.count) q_next = right;
      end
      iol_pkg::CMD_ROTATE: begin
        if (I + 1'b1 == ctrl.count) begin
          q_next = head;
        end else if (I + 1'b1 < ctrl.count) begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
